// File: rtl/assert_macros.svh
// Concurrent assertion helpers, sampled on clk and idle while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that an implication property holds on every clock.
`define KWM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition is never seen on a clock.
`define KWM_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define KWM_ASSERT(label, prop, msg)
`define KWM_NEVER(label, cond, msg)

`endif

`endif

// File: rtl/kwm_pkg.sv
package kwm_pkg;

  // Sizing of the row storage
  localparam int MAX_ROWS   = 8;
  localparam int ROW_DEPTH  = 8;
  localparam int VALUE_BITS = 32;

  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int IDX_W  = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
  localparam int CNT_W  = $clog2(ROW_DEPTH + 1);
  localparam int LEAVES = 1 << $clog2(MAX_ROWS);

  // Fixed port widths
  localparam int CMD_W    = 2;
  localparam int ROWSEL_W = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int SRC_W    = 3;
  localparam int RIU_W    = 4;

  localparam logic [RIU_W-1:0] ROWS_RESET = RIU_W'(8);

  // Register index on the configuration port
  localparam logic [0:0] REG_ROWS_IN_USE = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef logic [VALUE_BITS-1:0] elem_t;

  localparam elem_t SIGN_MASK = elem_t'(1) << (VALUE_BITS - 1);

  // Per-row strobes from the control logic
  typedef struct packed {
    logic clear;
    logic load;
    logic pop;
  } row_ctl_t;

  // Per-row occupancy flags
  typedef struct packed {
    logic nonempty;
    logic one_left;
    logic full;
  } row_stat_t;

  // Winner of the head comparison
  typedef struct packed {
    logic             found;
    logic [ROW_W-1:0] idx;
  } sel_t;

  // Sign-extend or truncate an input word to the element width
  function automatic elem_t fit_value(logic signed [DATA_W-1:0] v);
    return elem_t'(VALUE_BITS'(v));
  endfunction

  // Flip the sign bit so signed order becomes unsigned order
  function automatic elem_t order_key(elem_t v);
    return v ^ SIGN_MASK;
  endfunction

endpackage

// File: rtl/k_way_sorted_merge.sv
// K-way merge of sorted rows.
// Input channel (in_valid/in_ready) carries one command word: load appends
// in_value to row in_row, pop removes the smallest head among the rows in
// use (lower row wins a tie), clear empties every row.
// Result channel (out_valid/out_ready) returns exactly one word per command:
// status, popped value, its source row and a flag for the final element.
// Config port (APB): register 0 at byte address 0 is rows_in_use.
// A command waits in the input register; its result is registered once the
// result register is free or being taken. Throughput: one word per cycle
// with no stall; a pop is picked by a comparator tree over row head registers.
// Reset clears all rows and sets rows_in_use to 8; no clearing pass is run.
// A stalled receiver holds the result; one more command waits in the input
// register, after which in_ready drops until the result is taken.
`include "assert_macros.svh"

module k_way_sorted_merge
  import kwm_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic        [CMD_W-1:0]    in_cmd,
  input  logic        [ROWSEL_W-1:0] in_row,
  input  logic signed [DATA_W-1:0]   in_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic        [STATUS_W-1:0] out_status,
  output logic signed [DATA_W-1:0]   out_value,
  output logic        [SRC_W-1:0]    out_source_row,
  output logic                       out_last,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic        [2:0]          paddr,
  input  logic        [31:0]         pwdata,
  output logic        [31:0]         prdata,
  output logic                       pready
);

  logic [RIU_W-1:0] rows_r;

  logic                       s1_valid_r;
  logic        [CMD_W-1:0]    s1_cmd_r;
  logic        [ROWSEL_W-1:0] s1_row_r;
  logic signed [DATA_W-1:0]   s1_value_r;

  logic                       out_valid_r;
  logic        [STATUS_W-1:0] out_status_r, res_status;
  logic signed [DATA_W-1:0]   out_value_r, res_value;
  logic        [SRC_W-1:0]    out_src_r, res_src;
  logic                       out_last_r, res_last;

  logic proc;

  row_ctl_t      ctl   [MAX_ROWS];
  row_stat_t     stat  [MAX_ROWS];
  elem_t         heads [MAX_ROWS];
  logic [MAX_ROWS-1:0] mask;
  logic [MAX_ROWS-1:0] others;
  logic [RIU_W:0]      active_n;
  sel_t          sel;
  elem_t         min_value;
  logic          row_oob;
  logic          row_full;
  logic          do_load;
  logic          do_pop;
  logic          do_clear;

  // Config register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= ROWS_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_ROWS_IN_USE) begin
      rows_r <= pwdata[RIU_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_ROWS_IN_USE) ? {{(32-RIU_W){1'b0}}, rows_r} : 32'd0;

  // Input register and handshake
  assign proc     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd_r   <= in_cmd;
      s1_row_r   <= in_row;
      s1_value_r <= in_value;
    end
  end

  // Clamp rows in use to 1 .. MAX_ROWS
  always_comb begin
    if (rows_r == '0) begin
      active_n = (RIU_W+1)'(1);
    end else if (32'(rows_r) > 32'(MAX_ROWS)) begin
      active_n = (RIU_W+1)'(MAX_ROWS);
    end else begin
      active_n = {1'b0, rows_r};
    end
  end

  // Row lanes
  for (genvar g = 0; g < MAX_ROWS; g++) begin : g_row
    kwm_row u_row (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl[g]),
      .load_value (fit_value(s1_value_r)),
      .head_value (heads[g]),
      .stat       (stat[g])
    );
    assign mask[g] = stat[g].nonempty && ((RIU_W+1)'(g) < active_n);
  end

  kwm_select u_select (
    .heads     (heads),
    .mask      (mask),
    .sel       (sel),
    .min_value (min_value)
  );

  // Decode command and build result
  assign row_oob  = (32'(s1_row_r) >= 32'(MAX_ROWS));
  assign row_full = row_oob ? 1'b1 : stat[ROW_W'(s1_row_r)].full;

  always_comb begin
    do_load    = 1'b0;
    do_pop     = 1'b0;
    do_clear   = 1'b0;
    res_status = ST_OK;
    res_value  = '0;
    res_src    = '0;
    res_last   = 1'b0;
    for (int i = 0; i < MAX_ROWS; i++) begin
      others[i] = mask[i] && (sel.idx != ROW_W'(i));
    end
    unique case (s1_cmd_r)
      CMD_LOAD: begin
        if (row_full) begin
          res_status = ST_FULL;
        end else begin
          do_load = 1'b1;
        end
      end
      CMD_POP: begin
        if (!sel.found) begin
          res_status = ST_EMPTY;
        end else begin
          do_pop    = 1'b1;
          res_value = DATA_W'(min_value);
          res_src   = SRC_W'(sel.idx);
          res_last  = stat[sel.idx].one_left && (others == '0);
        end
      end
      CMD_CLEAR: begin
        do_clear = 1'b1;
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  // Per-row strobes, qualified by the processing slot
  always_comb begin
    for (int i = 0; i < MAX_ROWS; i++) begin
      ctl[i].clear = proc && do_clear;
      ctl[i].load  = proc && do_load && (32'(s1_row_r) == 32'(i));
      ctl[i].pop   = proc && do_pop && (sel.idx == ROW_W'(i));
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_status_r <= res_status;
      out_value_r  <= res_value;
      out_src_r    <= res_src;
      out_last_r   <= res_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_value      = out_value_r;
  assign out_source_row = out_src_r;
  assign out_last       = out_last_r;

  // Checks
  `KWM_ASSERT(a_last_is_ok, out_valid_r && out_last_r |-> out_status_r == ST_OK, "last flag on a failed word")
  `KWM_ASSERT(a_err_zero, out_valid_r && out_status_r != ST_OK |-> out_value_r == 0 && out_src_r == 0, "error word carries data")
  `KWM_ASSERT(a_hold_s1, s1_valid_r && !proc |=> s1_valid_r, "pending command dropped")
  `KWM_NEVER(a_no_overrun, in_valid && in_ready && s1_valid_r && !proc, "input register overwritten")

endmodule

// File: rtl/kwm_row.sv
module kwm_row
  import kwm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  row_ctl_t  ctl,
  input  elem_t     load_value,
  output elem_t     head_value,
  output row_stat_t stat
);

  elem_t            mem [ROW_DEPTH];
  elem_t            head_val_r;
  logic [CNT_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] tail_r, tail_nxt;

  // Append at the tail slot
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mem[tail_r[IDX_W-1:0]] <= load_value;
    end
  end

  // Advance head and tail pointers
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (ctl.clear) begin
      head_nxt = '0;
      tail_nxt = '0;
    end else begin
      if (ctl.load) begin
        tail_nxt = tail_r + CNT_W'(1);
      end
      if (ctl.pop) begin
        head_nxt = head_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  // Register the head word; forward a load that lands on the new head slot
  always_ff @(posedge clk) begin
    if (ctl.load && (tail_r[IDX_W-1:0] == head_nxt[IDX_W-1:0])) begin
      head_val_r <= load_value;
    end else begin
      head_val_r <= mem[head_nxt[IDX_W-1:0]];
    end
  end

  // Present the current head and occupancy
  assign head_value    = head_val_r;
  assign stat.nonempty = (head_r < tail_r);
  assign stat.one_left = (head_r < tail_r) && ((head_r + CNT_W'(1)) == tail_r);
  assign stat.full     = (tail_r >= CNT_W'(ROW_DEPTH));

endmodule

// File: rtl/kwm_select.sv
module kwm_select
  import kwm_pkg::*;
(
  input  elem_t                heads [MAX_ROWS],
  input  logic  [MAX_ROWS-1:0] mask,
  output sel_t                 sel,
  output elem_t                min_value
);

  logic             node_vld [2*LEAVES];
  elem_t            node_key [2*LEAVES];
  logic [ROW_W-1:0] node_idx [2*LEAVES];

  // Comparator tree: leaves are row heads, lower row wins a tie
  always_comb begin
    for (int i = 0; i < 2*LEAVES; i++) begin
      node_vld[i] = 1'b0;
      node_key[i] = '0;
      node_idx[i] = '0;
    end
    for (int i = 0; i < MAX_ROWS; i++) begin
      node_vld[LEAVES+i] = mask[i];
      node_key[LEAVES+i] = order_key(heads[i]);
      node_idx[LEAVES+i] = ROW_W'(i);
    end
    for (int j = LEAVES - 1; j >= 1; j--) begin
      if (node_vld[2*j] && (!node_vld[2*j+1] || node_key[2*j] <= node_key[2*j+1])) begin
        node_vld[j] = 1'b1;
        node_key[j] = node_key[2*j];
        node_idx[j] = node_idx[2*j];
      end else begin
        node_vld[j] = node_vld[2*j+1];
        node_key[j] = node_key[2*j+1];
        node_idx[j] = node_idx[2*j+1];
      end
    end
  end

  assign sel.found = node_vld[1];
  assign sel.idx   = node_idx[1];
  assign min_value = order_key(node_key[1]);

endmodule

// File: dv/k_way_sorted_merge_tb.sv
`timescale 1ns / 100ps

module k_way_sorted_merge_tb
  import kwm_pkg::*;
();

  // Command code outside the defined set
  localparam logic [CMD_W-1:0] CMD_UNUSED      = 2'd3;
  localparam int               CYCLE_LIMIT     = 500000;
  localparam int               RANDOM_PHASES   = 10;
  localparam int               PHASE_WORDS     = 123;

  typedef struct {
    status_t                   status;
    logic signed [DATA_W-1:0]  value;
    logic        [SRC_W-1:0]   src;
    logic                      last;
  } merge_result_t;

  // Merge predictor plus the queue of results it owes the DUT
  class merge_scoreboard;
    logic signed [DATA_W-1:0] rows_mem [MAX_ROWS][ROW_DEPTH];
    logic [CNT_W-1:0]         head [MAX_ROWS];
    logic [CNT_W-1:0]         tail [MAX_ROWS];
    logic [RIU_W-1:0]         rows_cfg;
    merge_result_t            owed [$];
    int fails, n_load, n_full, n_pop, n_empty, n_clear, n_other, n_cfg;

    function new();
      rows_cfg = ROWS_RESET;
      for (int r = 0; r < MAX_ROWS; r++) begin
        head[r] = '0;
        tail[r] = '0;
      end
    endfunction

    function void set_rows(logic [RIU_W-1:0] v);
      rows_cfg = v;
      n_cfg++;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // Apply one accepted command word and queue the result it must produce
    function void note_command(logic [CMD_W-1:0] cmd, logic [ROWSEL_W-1:0] row,
                               logic signed [DATA_W-1:0] value);
      merge_result_t            res;
      int                       n;
      int                       best;
      int                       remaining;
      bit                       found;
      logic signed [DATA_W-1:0] best_val;
      res = '{ST_OK, '0, '0, 1'b0};
      found = 1'b0;
      best = 0;
      remaining = 0;
      best_val = '0;
      case (cmd)
        CMD_LOAD: begin
          if (tail[row] >= ROW_DEPTH) begin
            res.status = ST_FULL;
            n_full++;
          end else begin
            rows_mem[row][tail[row]] = value;
            tail[row] = tail[row] + 1'b1;
            n_load++;
          end
        end
        CMD_POP: begin
          // Clamp the row count into 1 .. MAX_ROWS
          n = (rows_cfg == 0) ? 1 : ((rows_cfg > MAX_ROWS) ? MAX_ROWS : int'(rows_cfg));
          for (int r = 0; r < n; r++) begin
            if (head[r] < tail[r]) begin
              remaining += int'(tail[r]) - int'(head[r]);
              // Strict compare keeps the lower row on a tie
              if (!found || rows_mem[r][head[r]] < best_val) begin
                found = 1'b1;
                best = r;
                best_val = rows_mem[r][head[r]];
              end
            end
          end
          if (!found) begin
            res.status = ST_EMPTY;
            n_empty++;
          end else begin
            head[best] = head[best] + 1'b1;
            res.value = best_val;
            res.src = SRC_W'(best);
            res.last = (remaining == 1);
            n_pop++;
          end
        end
        CMD_CLEAR: begin
          for (int r = 0; r < MAX_ROWS; r++) begin
            head[r] = '0;
            tail[r] = '0;
          end
          n_clear++;
        end
        default: n_other++;
      endcase
      owed = {owed, res};
    endfunction

    // Compare one accepted result word against the oldest owed result
    function void check_result(logic [STATUS_W-1:0] status, logic signed [DATA_W-1:0] value,
                               logic [SRC_W-1:0] src, logic last);
      merge_result_t exp_res;
      if (owed.size() == 0) begin
        $error("result word with no command pending");
        fails++;
        return;
      end
      exp_res = owed.pop_front();
      if (status !== exp_res.status) begin
        $error("out_status: expected %0d, got %0d", exp_res.status, status);
        fails++;
      end
      if (value !== exp_res.value) begin
        $error("out_value: expected %0d, got %0d", exp_res.value, value);
        fails++;
      end
      if (src !== exp_res.src) begin
        $error("out_source_row: expected %0d, got %0d", exp_res.src, src);
        fails++;
      end
      if (last !== exp_res.last) begin
        $error("out_last: expected %0d, got %0d", exp_res.last, last);
        fails++;
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic        [CMD_W-1:0]    in_cmd;
  logic        [ROWSEL_W-1:0] in_row;
  logic signed [DATA_W-1:0]   in_value;
  logic                       out_valid;
  logic                       out_ready;
  logic        [STATUS_W-1:0] out_status;
  logic signed [DATA_W-1:0]   out_value;
  logic        [SRC_W-1:0]    out_source_row;
  logic                       out_last;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic        [2:0]          paddr;
  logic        [31:0]         pwdata;
  logic        [31:0]         prdata;
  logic                       pready;

  merge_scoreboard sb;
  bit              no_idle;
  int              cycles;
  longint          row_last [MAX_ROWS];
  bit              row_started [MAX_ROWS];

  k_way_sorted_merge u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_row         (in_row),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_value      (out_value),
    .out_source_row (out_source_row),
    .out_last       (out_last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Send one command word, holding it until the DUT takes it
  task automatic send_word(logic [CMD_W-1:0] cmd, logic [ROWSEL_W-1:0] row,
                           logic signed [DATA_W-1:0] value);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_row   <= row;
    in_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_command(cmd, row, value);
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic drain(int settle);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // APB write to a register index, setup phase then access phase; pready is sampled in the access cycle
  task automatic cfg_write(logic [0:0] idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_ROWS_IN_USE) sb.set_rows(data[RIU_W-1:0]);
  endtask

  // Mostly ascending loads per row, mixed with pops, clears and noise
  task automatic random_phase(int count, int load_pct, int clear_pct);
    int                       pick;
    longint                   nv;
    logic [ROWSEL_W-1:0]      r;
    logic signed [DATA_W-1:0] v;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < load_pct) begin
        r = ROWSEL_W'($urandom());
        if ($urandom_range(0, 19) == 0) begin
          v = $urandom();
        end else begin
          if (!row_started[r]) begin
            case ($urandom_range(0, 3))
              0:       nv = longint'($signed($urandom()));
              1:       nv = longint'($urandom_range(0, 40)) - 20;
              2:       nv = -64'sd2147483648;
              default: nv = 64'sd2147483640 + longint'($urandom_range(0, 7));
            endcase
          end else begin
            case ($urandom_range(0, 3))
              0:       nv = row_last[r];
              1:       nv = row_last[r] + longint'($urandom_range(1, 10));
              default: nv = row_last[r] + longint'($urandom_range(0, 32'h0FFF_FFFF));
            endcase
          end
          if (nv > 64'sd2147483647) nv = 64'sd2147483647;
          row_last[r] = nv;
          row_started[r] = 1'b1;
          v = nv[DATA_W-1:0];
        end
        send_word(CMD_LOAD, r, v);
      end else if (pick < 100 - clear_pct - 2) begin
        send_word(CMD_POP, ROWSEL_W'($urandom()), $urandom());
      end else if (pick < 98) begin
        send_word(CMD_CLEAR, ROWSEL_W'($urandom()), $urandom());
        for (int i = 0; i < MAX_ROWS; i++) row_started[i] = 1'b0;
      end else begin
        send_word(CMD_UNUSED, ROWSEL_W'($urandom()), $urandom());
      end
    end
  endtask

  // Result side: stall for a random count, then take one word
  initial begin
    int stall;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_result(out_status, out_value, out_source_row, out_last);
    end
  end

  initial begin
    logic [RIU_W-1:0] rows_sel;
    sb = new();
    no_idle = 1'b0;
    cycles = 0;
    for (int i = 0; i < MAX_ROWS; i++) row_started[i] = 1'b0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_cmd   <= CMD_LOAD;
    in_row   <= '0;
    in_value <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty pop, extremes, tie on equal heads, last element
    send_word(CMD_POP, 3'd5, 32'h1234_5678);
    send_word(CMD_LOAD, 3'd0, 32'sh7FFF_FFFF);
    send_word(CMD_LOAD, 3'd7, 32'sh8000_0000);
    send_word(CMD_LOAD, 3'd3, -32'sd1);
    send_word(CMD_LOAD, 3'd5, -32'sd1);
    repeat (5) send_word(CMD_POP, 3'd7, 32'hFFFF_FFFF);
    send_word(CMD_UNUSED, 3'd7, 32'hFFFF_FFFF);
    // Fill one row past its depth
    for (int i = 0; i <= ROW_DEPTH; i++) send_word(CMD_LOAD, 3'd2, i);
    send_word(CMD_CLEAR, 3'd0, '0);
    send_word(CMD_POP, 3'd0, '0);
    drain(4);
    // A load into a row outside the merge stays hidden until the count covers it
    cfg_write(REG_ROWS_IN_USE, 32'd1);
    send_word(CMD_LOAD, 3'd1, 32'sd5);
    send_word(CMD_POP, 3'd0, '0);
    drain(4);
    cfg_write(REG_ROWS_IN_USE, 32'd2);
    send_word(CMD_POP, 3'd0, '0);
    drain(4);

    // Random phases, each under a new row count and traffic mix
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       rows_sel = 4'd0;
        1:       rows_sel = 4'd15;
        2:       rows_sel = 4'd1;
        3:       rows_sel = 4'd8;
        default: rows_sel = RIU_W'($urandom());
      endcase
      cfg_write(REG_ROWS_IN_USE, {28'($urandom()), rows_sel});
      no_idle = ($urandom_range(0, 3) == 0);
      random_phase(PHASE_WORDS, $urandom_range(30, 70), $urandom_range(0, 4));
      drain(4);
    end

    no_idle = 1'b0;
    drain(10);
    $display("Ran %0d loads, %0d full-row rejects, %0d pops, %0d empty pops,",
             sb.n_load, sb.n_full, sb.n_pop, sb.n_empty);
    $display("%0d clears, %0d undefined commands over %0d row-count settings.",
             sb.n_clear, sb.n_other, sb.n_cfg);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
